>>> sv/so3em_pkg.sv
`timescale 1ns / 1ps

package so3em_pkg;

  // Fraction bits of the rotation vector and the angle limit
  localparam int ANGLE_FRAC_BITS = 27;

  // Series path shifts into the 32-fraction-bit working format
  localparam int SER_SHL = (ANGLE_FRAC_BITS < 32) ? (32 - ANGLE_FRAC_BITS) : 0;
  localparam int SER_SHR = (ANGLE_FRAC_BITS >= 32) ? (ANGLE_FRAC_BITS - 32) : 0;
  localparam int W2_SHR  = 2 * ANGLE_FRAC_BITS - 31;

  // Unity in Q1.30, kept one bit wider for signed arithmetic
  localparam logic [32:0] ONE_Q30 = 33'd1073741824;

  // Sine/cosine rotator in turn units
  localparam int          CORDIC_STEPS    = 30;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [63:0] INV_TWO_PI_Q64  = 64'h28BE60DB9391054A;

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // Front end to square root: normalized squared norm
  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [63:0]      nn;
    logic [4:0]       m;
  } front_t;

  // Square root to axis/trig: integer root of the normalized norm
  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [4:0]       m;
    logic [31:0]      rt;
  } sq_t;

  // Axis/trig to matrix assembly: unit axis Q1.30, sine and cosine Q1.30
  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [2:0][31:0] k;
    logic [31:0]      s;
    logic [31:0]      c;
  } kt_t;

endpackage

>>> sv/so3em_front.sv
`timescale 1ns / 1ps

module so3em_front import so3em_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  logic [2:0][31:0] w_i,
  input  logic [30:0]      limit_i,
  output logic             out_valid_o,
  output front_t           out_o
);

  localparam int NSTEP = 5;

  logic                   va_q, vb_q;
  logic [2:0][31:0]       wa_q, wb_q;
  logic [2:0][62:0]       sqa_q, sqa_d;
  logic [61:0]            lsqa_q, lsqa_d, lsqb_q;
  logic [63:0]            n2b_q, n2b_d;
  logic [NSTEP-1:0]       nv_q;
  front_t                 ns_q [NSTEP];
  front_t                 ns_d [NSTEP];

  // Square the components and the limit
  always_comb begin
    logic signed [63:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod       = $signed(w_i[i]) * $signed(w_i[i]);
      sqa_d[i]   = prod[62:0];
    end
    lsqa_d = {31'd0, limit_i} * {31'd0, limit_i};
  end

  // Sum the squares
  assign n2b_d = {1'b0, sqa_q[0]} + {1'b0, sqa_q[1]} + {1'b0, sqa_q[2]};

  // Normalize: shift by pairs of bits until the norm reaches 2^60
  always_comb begin
    front_t src;
    int     sh;
    for (int k = 0; k < NSTEP; k++) begin
      if (k == 0) begin
        src.w      = wb_q;
        src.series = (n2b_q < {2'b00, lsqb_q});
        src.zero   = (n2b_q == '0);
        src.nn     = n2b_q;
        src.m      = '0;
      end else begin
        src = ns_q[k-1];
      end
      sh       = 16 >> k;
      ns_d[k]  = src;
      if (src.nn < (64'd1 << (62 - 2 * sh))) begin
        ns_d[k].nn = src.nn << (2 * sh);
        ns_d[k].m  = src.m + 5'(sh);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      nv_q <= '0;
    end else if (en_i) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      nv_q <= {nv_q[NSTEP-2:0], vb_q};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q   <= w_i;
      sqa_q  <= sqa_d;
      lsqa_q <= lsqa_d;
      wb_q   <= wa_q;
      n2b_q  <= n2b_d;
      lsqb_q <= lsqa_q;
      for (int k = 0; k < NSTEP; k++) ns_q[k] <= ns_d[k];
    end
  end

  assign out_valid_o = nv_q[NSTEP-1];
  assign out_o       = ns_q[NSTEP-1];

`ifndef NO_ASSERTIONS
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.zero |-> out_o.nn[63:60] != 4'd0)
    else $error("normalized norm below 2^60");
`endif

endmodule

>>> sv/so3em_sqrt.sv
`timescale 1ns / 1ps

module so3em_sqrt import so3em_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   in_valid_i,
  input  front_t in_i,
  output logic   out_valid_o,
  output sq_t    out_o
);

  localparam int NST = 32;

  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [4:0]       m;
    logic [63:0]      op;
    logic [63:0]      res;
  } sqst_t;

  logic [NST-1:0] v_q;
  sqst_t          st_q [NST];
  sqst_t          st_d [NST];

  // One result bit per stage
  always_comb begin
    sqst_t       src;
    logic [63:0] one_v;
    logic [63:0] trial;
    for (int j = 0; j < NST; j++) begin
      if (j == 0) begin
        src.w      = in_i.w;
        src.series = in_i.series;
        src.zero   = in_i.zero;
        src.m      = in_i.m;
        src.op     = in_i.nn;
        src.res    = '0;
      end else begin
        src = st_q[j-1];
      end
      one_v   = 64'd1 << (62 - 2 * j);
      trial   = src.res + one_v;
      st_d[j] = src;
      if (src.op >= trial) begin
        st_d[j].op  = src.op - trial;
        st_d[j].res = (src.res >> 1) + one_v;
      end else begin
        st_d[j].res = src.res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NST; j++) st_q[j] <= st_d[j];
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign out_o.w      = st_q[NST-1].w;
  assign out_o.series = st_q[NST-1].series;
  assign out_o.zero   = st_q[NST-1].zero;
  assign out_o.m      = st_q[NST-1].m;
  assign out_o.rt     = st_q[NST-1].res[31:0];

`ifndef NO_ASSERTIONS
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.zero |-> out_o.rt[31:30] != 2'd0)
    else $error("root of normalized norm below 2^30");
`endif

endmodule

>>> sv/so3em_kt.sv
`timescale 1ns / 1ps

module so3em_kt import so3em_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  sq_t  in_i,
  output logic out_valid_o,
  output kt_t  out_o
);

  // Stage 0 prepares, 1..31 divide, 1..2 form the phase, 3.. rotate
  localparam int LAST = 2 + CORDIC_STEPS;
  localparam int NV   = LAST + 2;

  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [4:0]       m;
    logic [31:0]      rt;
    logic [2:0]       sgn;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] nlo;
    logic [2:0][30:0] q;
    logic [63:0]      pl;
    logic [63:0]      ph;
    logic [63:0]      hi;
    logic [6:0]       e;
    logic [32:0]      x;
    logic [32:0]      y;
    logic [32:0]      z;
    logic [1:0]       quad;
  } kst_t;

  logic [NV-1:0] v_q;
  kst_t          st_q [LAST+1];
  kst_t          st_d [LAST+1];
  kt_t           out_q, out_d;

  function automatic logic [31:0] clamp_unit(logic [32:0] v);
    logic [32:0] r;
    if ($signed(v) > $signed(ONE_Q30)) r = ONE_Q30;
    else if ($signed(v) < -$signed(ONE_Q30)) r = -ONE_Q30;
    else r = v;
    return r[31:0];
  endfunction

  always_comb begin
    logic [31:0]        absw;
    logic [61:0]        shw;
    logic [61:0]        a_v;
    logic [62:0]        num;
    logic [32:0]        rem2;
    logic [63:0]        shv;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        at;

    // Prepare numerators and the phase partial products
    st_d[0]        = '0;
    st_d[0].w      = in_i.w;
    st_d[0].series = in_i.series;
    st_d[0].zero   = in_i.zero;
    st_d[0].m      = in_i.m;
    st_d[0].rt     = in_i.rt;
    for (int i = 0; i < 3; i++) begin
      absw             = in_i.w[i][31] ? (~in_i.w[i] + 32'd1) : in_i.w[i];
      shw              = {30'd0, absw} << in_i.m;
      a_v              = (shw > {30'd0, in_i.rt}) ? {30'd0, in_i.rt} : shw;
      num              = {1'b0, a_v[31:0], 30'd0} + {32'd0, in_i.rt[31:1]};
      st_d[0].sgn[i]   = in_i.w[i][31];
      st_d[0].rem[i]   = num[62:31];
      st_d[0].nlo[i]   = num[30:0];
    end
    st_d[0].pl = in_i.rt * INV_TWO_PI_Q64[31:0];
    st_d[0].ph = in_i.rt * INV_TWO_PI_Q64[63:32];

    for (int j = 1; j <= LAST; j++) begin
      st_d[j] = st_q[j-1];

      // Restoring divide: one quotient bit per stage
      if (j <= 31) begin
        for (int i = 0; i < 3; i++) begin
          rem2 = {st_q[j-1].rem[i], st_q[j-1].nlo[i][5'(31 - j)]};
          if (rem2 >= {1'b0, st_q[j-1].rt}) begin
            rem2                        = rem2 - {1'b0, st_q[j-1].rt};
            st_d[j].q[i][5'(31 - j)]    = 1'b1;
          end else begin
            st_d[j].q[i][5'(31 - j)]    = 1'b0;
          end
          st_d[j].rem[i] = rem2[31:0];
        end
      end

      // Combine partial products into the turn count
      if (j == 1) begin
        st_d[j].hi = st_q[j-1].ph + {32'd0, st_q[j-1].pl[63:32]};
        st_d[j].e  = 7'(ANGLE_FRAC_BITS) + {2'b00, st_q[j-1].m};
      end

      // Scale to the phase and seed the rotator
      if (j == 2) begin
        shv          = st_q[j-1].hi >> st_q[j-1].e;
        st_d[j].x    = {1'b0, CORDIC_GAIN_Q30};
        st_d[j].y    = '0;
        st_d[j].z    = {3'b000, shv[29:0]};
        st_d[j].quad = shv[31:30];
      end

      // Rotator step
      if (j >= 3) begin
        dx = $signed(st_q[j-1].y) >>> (j - 3);
        dy = $signed(st_q[j-1].x) >>> (j - 3);
        at = {3'b000, ATAN_TURNS[5'(j - 3)]};
        if (!st_q[j-1].z[32]) begin
          st_d[j].x = st_q[j-1].x - dx;
          st_d[j].y = st_q[j-1].y + dy;
          st_d[j].z = st_q[j-1].z - at;
        end else begin
          st_d[j].x = st_q[j-1].x + dx;
          st_d[j].y = st_q[j-1].y - dy;
          st_d[j].z = st_q[j-1].z + at;
        end
      end
    end
  end

  // Clamp, apply the quadrant, sign the axis
  always_comb begin
    logic [31:0] cx;
    logic [31:0] cy;
    cx           = clamp_unit(st_q[LAST].x);
    cy           = clamp_unit(st_q[LAST].y);
    out_d.w      = st_q[LAST].w;
    out_d.series = st_q[LAST].series;
    out_d.zero   = st_q[LAST].zero;
    for (int i = 0; i < 3; i++) begin
      out_d.k[i] = st_q[LAST].sgn[i] ? (~{1'b0, st_q[LAST].q[i]} + 32'd1)
                                     : {1'b0, st_q[LAST].q[i]};
    end
    unique case (st_q[LAST].quad)
      2'd0: begin out_d.c = cx;       out_d.s = cy;       end
      2'd1: begin out_d.c = -cy;      out_d.s = cx;       end
      2'd2: begin out_d.c = -cx;      out_d.s = -cy;      end
      default: begin out_d.c = cy;    out_d.s = -cx;      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NV-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j <= LAST; j++) st_q[j] <= st_d[j];
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NV-1];
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_o.s) <= 32'sd1073741824)
                 && ($signed(out_o.s) >= -32'sd1073741824)
                 && ($signed(out_o.c) <= 32'sd1073741824)
                 && ($signed(out_o.c) >= -32'sd1073741824))
    else $error("sine or cosine outside unit range");
`endif

endmodule

>>> sv/so3em_mat.sv
`timescale 1ns / 1ps

module so3em_mat import so3em_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         in_valid_i,
  input  kt_t          in_i,
  output logic         out_valid_o,
  output logic [287:0] out_o
);

  typedef struct packed {
    logic [2:0][31:0] w;
    logic             series;
    logic             zero;
    logic [5:0][63:0] p;
    logic [2:0][63:0] sk;
    logic [32:0]      omc;
  } m0_t;

  typedef struct packed {
    logic             series;
    logic             zero;
    logic [2:0][63:0] sk;
    logic [8:0][65:0] t2;
    logic [8:0][65:0] ser;
  } m1_t;

  typedef struct packed {
    logic             series;
    logic             zero;
    logic [8:0][65:0] pre;
  } m2_t;

  logic [3:0]   v_q;
  m0_t          m0_q, m0_d;
  m1_t          m1_q, m1_d;
  m2_t          m2_q, m2_d;
  logic [287:0] out_q, out_d;

  // Products 00, 11, 22, 01, 02, 12
  function automatic int prow(int idx);
    return (idx == 5) ? 1 : ((idx < 3) ? idx : 0);
  endfunction

  function automatic int pcol(int idx);
    return (idx < 3) ? idx : ((idx == 3) ? 1 : 2);
  endfunction

  function automatic int pidx(int r, int c);
    int lo;
    int hi;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    if (lo == hi) return lo;
    if (lo == 0) return (hi == 1) ? 3 : 4;
    return 5;
  endfunction

  function automatic logic signed [65:0] skew66(int r, int c, logic signed [65:0] v0,
                                                 logic signed [65:0] v1, logic signed [65:0] v2);
    logic signed [65:0] t;
    t = '0;
    if (r == 0 && c == 1) t = -v2;
    if (r == 0 && c == 2) t = v1;
    if (r == 1 && c == 0) t = v2;
    if (r == 1 && c == 2) t = -v0;
    if (r == 2 && c == 0) t = -v1;
    if (r == 2 && c == 1) t = v0;
    return t;
  endfunction

  function automatic logic [31:0] sat32(logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Products: axis pairs, or vector pairs on the series path
  always_comb begin
    logic signed [31:0] a_op;
    logic signed [31:0] b_op;
    m0_d.w      = in_i.w;
    m0_d.series = in_i.series;
    m0_d.zero   = in_i.zero;
    for (int i = 0; i < 6; i++) begin
      a_op      = in_i.series ? $signed(in_i.w[prow(i)]) : $signed(in_i.k[prow(i)]);
      b_op      = in_i.series ? $signed(in_i.w[pcol(i)]) : $signed(in_i.k[pcol(i)]);
      m0_d.p[i] = a_op * b_op;
    end
    for (int i = 0; i < 3; i++) begin
      m0_d.sk[i] = $signed(in_i.s) * $signed(in_i.k[i]);
    end
    m0_d.omc = ONE_Q30 - {in_i.c[31], in_i.c};
  end

  // Round axis products and weight them; form series sums
  always_comb begin
    logic signed [63:0] kr;
    logic signed [32:0] kkm;
    logic signed [65:0] w2;
    logic signed [65:0] wq;
    logic signed [65:0] wv [3];
    logic signed [65:0] pv;
    m1_d.series = m0_q.series;
    m1_d.zero   = m0_q.zero;
    m1_d.sk     = m0_q.sk;
    for (int i = 0; i < 3; i++) begin
      wv[i] = {{34{m0_q.w[i][31]}}, m0_q.w[i]};
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        kr  = $signed(m0_q.p[pidx(r, c)]) + 64'sd536870912;
        kr  = kr >>> 30;
        kkm = $signed(kr[32:0]) - ((r == c) ? $signed(ONE_Q30) : 33'sd0);
        m1_d.t2[r*3+c] = $signed(m0_q.omc) * kkm;

        pv = {{2{m0_q.p[pidx(r, c)][63]}}, m0_q.p[pidx(r, c)]};
        if (r == c) begin
          w2 = -($signed({{2{m0_q.p[(r + 1) % 3][63]}}, m0_q.p[(r + 1) % 3]})
               + $signed({{2{m0_q.p[(r + 2) % 3][63]}}, m0_q.p[(r + 2) % 3]}));
        end else begin
          w2 = pv;
        end
        wq = (skew66(r, c, wv[0], wv[1], wv[2]) <<< SER_SHL) >>> SER_SHR;
        m1_d.ser[r*3+c] = ((r == c) ? (66'sd1 <<< 32) : 66'sd0) + wq + (w2 >>> W2_SHR);
      end
    end
  end

  // Sum the terms and add the rounding offset
  always_comb begin
    logic signed [65:0] sv [3];
    logic signed [65:0] rod;
    m2_d.series = m1_q.series;
    m2_d.zero   = m1_q.zero;
    for (int i = 0; i < 3; i++) begin
      sv[i] = {{2{m1_q.sk[i][63]}}, m1_q.sk[i]};
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rod = ((r == c) ? (66'sd1 <<< 60) : 66'sd0) + skew66(r, c, sv[0], sv[1], sv[2])
            + $signed(m1_q.t2[r*3+c]) + (66'sd1 <<< 30);
        m2_d.pre[r*3+c] = m1_q.series ? ($signed(m1_q.ser[r*3+c]) + 66'sd4) : rod;
      end
    end
  end

  // Scale, saturate, select the identity for a zero vector
  always_comb begin
    logic signed [65:0] shd;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        shd = m2_q.series ? ($signed(m2_q.pre[r*3+c]) >>> 3)
                          : ($signed(m2_q.pre[r*3+c]) >>> 31);
        if (m2_q.zero && !m2_q.series) begin
          out_d[(r*3+c)*32 +: 32] = (r == c) ? 32'h20000000 : 32'h0;
        end else begin
          out_d[(r*3+c)*32 +: 32] = sat32(shd);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q  <= m0_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_omc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !m0_q.series |-> !m0_q.omc[32] && (m0_q.omc <= {ONE_Q30[31:0], 1'b0}))
    else $error("one minus cosine outside [0, 2]");
`endif

endmodule

>>> sv/so3_exponential_map_unit.sv
`timescale 1ns / 1ps

// Rodrigues exponential map: a rotation vector (x, y, z, signed Q4.27 radians)
// goes in, the row-major 3x3 rotation matrix (signed Q2.29, saturated) comes
// out. Below the configured small-angle limit the second-order series is
// returned instead. The pipeline takes one vector per clock while the output
// is not held. It squares and normalizes the norm, takes the bit-per-stage
// square root, runs the axis divider (31 quotient bits) beside the 30-step
// sine/cosine rotator, and assembles the matrix. When the output is held,
// the whole pipeline stalls with it and s_axis_tready drops.
// The limit register takes writes at any time the block is idle.
module so3_exponential_map_unit import so3em_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // rot_x, rot_y, rot_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i      // small_angle_limit
);

  logic             en;
  logic [30:0]      limit_q;
  logic [2:0][31:0] w_in;
  logic             fr_valid, sq_valid, kt_valid;
  front_t           fr;
  sq_t              sq;
  kt_t              kt;

  // Advance the pipeline unless the output request is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;
  assign w_in          = s_axis_tdata;

  // Hold the small-angle limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 31'd134;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  so3em_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .w_i         (w_in),
    .limit_i     (limit_q),
    .out_valid_o (fr_valid),
    .out_o       (fr)
  );

  so3em_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (fr_valid),
    .in_i        (fr),
    .out_valid_o (sq_valid),
    .out_o       (sq)
  );

  so3em_kt u_kt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sq_valid),
    .in_i        (sq),
    .out_valid_o (kt_valid),
    .out_o       (kt)
  );

  so3em_mat u_mat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (kt_valid),
    .in_i        (kt),
    .out_valid_o (m_axis_tvalid),
    .out_o       (m_axis_tdata)
  );

endmodule
